>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> rtl/core/idfp_pkg.sv
// Package with beat types and frame layout constants for the IMU frame parser.
`timescale 1ns / 1ps

package idfp_pkg;

    // Beat kinds on the input channel
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    // Burst buffer size: the byte count saturates here
    localparam logic [7:0] BUFFER_SIZE = 8'd32;

    // Frame layout
    localparam logic [7:0] FRAME_LEN   = 8'd22;
    localparam logic [7:0] SUM_LEN     = 8'd10;
    localparam logic [7:0] SECOND_PKT  = 8'd11;
    localparam logic [7:0] POS_SYNC_A  = 8'd0;
    localparam logic [7:0] POS_TYPE_A  = 8'd1;
    localparam logic [7:0] POS_RATE_LO = 8'd6;
    localparam logic [7:0] POS_RATE_HI = 8'd7;
    localparam logic [7:0] POS_CSUM_A  = 8'd10;
    localparam logic [7:0] POS_SYNC_B  = 8'd11;
    localparam logic [7:0] POS_TYPE_B  = 8'd12;
    localparam logic [7:0] POS_YAW_LO  = 8'd17;
    localparam logic [7:0] POS_YAW_HI  = 8'd18;
    localparam logic [7:0] POS_CSUM_B  = 8'd21;

    // Header byte values
    localparam logic [7:0] HDR_SYNC  = 8'h55;
    localparam logic [7:0] HDR_RATE  = 8'h52;
    localparam logic [7:0] HDR_ANGLE = 8'h53;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic               frame_ok;
        logic signed [15:0] rate_raw;
        logic signed [15:0] yaw_raw;
    } t_out_beat;

endpackage

>>> rtl/core/idfp_frame_acc.sv
// Running frame accumulator: checks header bytes, captures checksum and payload bytes and sums.
`timescale 1ns / 1ps

module idfp_frame_acc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_beat_take,
    input  idfp_pkg::t_in_beat  i_beat,
    output idfp_pkg::t_out_beat o_result
);

    logic [7:0] r_count, n_count;
    logic       r_hdr_ok, n_hdr_ok;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;
    logic [7:0] r_csum_a, n_csum_a;
    logic [7:0] r_csum_b, n_csum_b;
    logic [7:0] r_rate_lo, n_rate_lo;
    logic [7:0] r_rate_hi, n_rate_hi;
    logic [7:0] r_yaw_lo, n_yaw_lo;
    logic [7:0] r_yaw_hi, n_yaw_hi;
    logic       w_store;
    logic       w_ok;

    // Store a byte only while the count is below the buffer size
    assign w_store = i_beat_take && (i_beat.kind == idfp_pkg::KIND_DATA) &&
                     (r_count < idfp_pkg::BUFFER_SIZE);

    // Advance count, sums and captured bytes; restart on an idle beat
    always_comb begin
        n_count   = r_count;
        n_hdr_ok  = r_hdr_ok;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_csum_a  = r_csum_a;
        n_csum_b  = r_csum_b;
        n_rate_lo = r_rate_lo;
        n_rate_hi = r_rate_hi;
        n_yaw_lo  = r_yaw_lo;
        n_yaw_hi  = r_yaw_hi;
        if (i_beat_take && (i_beat.kind == idfp_pkg::KIND_IDLE)) begin
            n_count  = '0;
            n_hdr_ok = 1'b1;
            n_sum_a  = '0;
            n_sum_b  = '0;
        end else if (w_store) begin
            n_count = r_count + 8'd1;
            if (r_count < idfp_pkg::SUM_LEN) begin
                n_sum_a = r_sum_a + i_beat.data_byte;
            end
            if ((r_count >= idfp_pkg::SECOND_PKT) &&
                (r_count < idfp_pkg::SECOND_PKT + idfp_pkg::SUM_LEN)) begin
                n_sum_b = r_sum_b + i_beat.data_byte;
            end
            unique case (r_count)
                idfp_pkg::POS_SYNC_A: begin
                    if (i_beat.data_byte != idfp_pkg::HDR_SYNC) n_hdr_ok = 1'b0;
                end
                idfp_pkg::POS_TYPE_A: begin
                    if (i_beat.data_byte != idfp_pkg::HDR_RATE) n_hdr_ok = 1'b0;
                end
                idfp_pkg::POS_SYNC_B: begin
                    if (i_beat.data_byte != idfp_pkg::HDR_SYNC) n_hdr_ok = 1'b0;
                end
                idfp_pkg::POS_TYPE_B: begin
                    if (i_beat.data_byte != idfp_pkg::HDR_ANGLE) n_hdr_ok = 1'b0;
                end
                idfp_pkg::POS_RATE_LO: n_rate_lo = i_beat.data_byte;
                idfp_pkg::POS_RATE_HI: n_rate_hi = i_beat.data_byte;
                idfp_pkg::POS_CSUM_A:  n_csum_a  = i_beat.data_byte;
                idfp_pkg::POS_YAW_LO:  n_yaw_lo  = i_beat.data_byte;
                idfp_pkg::POS_YAW_HI:  n_yaw_hi  = i_beat.data_byte;
                idfp_pkg::POS_CSUM_B:  n_csum_b  = i_beat.data_byte;
                default: begin
                end
            endcase
        end
    end

    // Hold control state under reset; captured bytes need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hdr_ok <= 1'b1;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
        end else begin
            r_count  <= n_count;
            r_hdr_ok <= n_hdr_ok;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
        end
        r_csum_a  <= n_csum_a;
        r_csum_b  <= n_csum_b;
        r_rate_lo <= n_rate_lo;
        r_rate_hi <= n_rate_hi;
        r_yaw_lo  <= n_yaw_lo;
        r_yaw_hi  <= n_yaw_hi;
    end

    // Judge the burst: length, headers and both checksums
    assign w_ok = (r_count >= idfp_pkg::FRAME_LEN) && r_hdr_ok &&
                  (r_csum_a == r_sum_a) && (r_csum_b == r_sum_b);

    always_comb begin
        o_result.frame_ok = w_ok;
        o_result.rate_raw = w_ok ? $signed({r_rate_hi, r_rate_lo}) : 16'sd0;
        o_result.yaw_raw  = w_ok ? $signed({r_yaw_hi, r_yaw_lo}) : 16'sd0;
    end

endmodule

>>> rtl/core/imu_dual_frame_parser_top.sv
// IMU dual frame parser: the result of an accepted idle beat is registered and shown on the next cycle.
// Throughput: one input beat per cycle, data or idle, while the result register is empty or being taken.
// Data beats produce no result; every idle beat produces exactly one.
// The result register frees the input side whenever it is empty or being taken.
// Synchronous active-low reset clears the byte count, sums and output valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module imu_dual_frame_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  idfp_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output idfp_pkg::t_out_beat o_out_data
);

    logic                r_out_valid;
    idfp_pkg::t_out_beat r_out_data;
    idfp_pkg::t_out_beat w_result;
    logic                w_in_take;
    logic                w_idle_take;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_idle_take = w_in_take && (i_in_data.kind == idfp_pkg::KIND_IDLE);

    idfp_frame_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat_take (w_in_take),
        .i_beat      (i_in_data),
        .o_result    (w_result)
    );

    // Load the result on an idle beat; drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_idle_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_idle_take) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An idle beat always yields a result on the next cycle
    `ASSERT_CLK(a_idle_gives_result, i_clk, i_rst_n, w_idle_take |=> o_out_valid)
    // A data beat never raises output valid
    `ASSERT_CLK(a_data_no_result, i_clk, i_rst_n,
        (w_in_take && !w_idle_take && !o_out_valid) |=> !o_out_valid)
    // A failed frame reports zero rate and yaw
    `ASSERT_NEVER(a_fail_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.frame_ok &&
        ((o_out_data.rate_raw != 16'sd0) || (o_out_data.yaw_raw != 16'sd0)))

endmodule
